// ===== hdl/shfr_pkg.sv =====
// shared types and constants for the sync header frame receiver
// no dependencies; imported by every module of the block
package shfr_pkg;

  localparam int unsigned MAX_LEN      = 255;
  localparam int unsigned HDR_SIZE     = 5;
  localparam int unsigned PAYLOAD_EXTRA = 5;
  localparam logic [7:0]  SYNC_BYTE    = 8'h5A;

  // result status codes
  localparam logic [1:0] ST_HDR_STORED  = 2'd0;
  localparam logic [1:0] ST_HDR_REJECT  = 2'd1;
  localparam logic [1:0] ST_HDR_ACCEPT  = 2'd2;
  localparam logic [1:0] ST_PAYLOAD     = 2'd3;

  // phase codes
  localparam logic PH_HEADER  = 1'b0;
  localparam logic PH_PAYLOAD = 1'b1;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data_byte;
    logic [8:0] byte_index;
    logic [7:0] msg_length;
    logic [7:0] msg_kind;
    logic       last;
  } result_t;

endpackage

// ===== hdl/sync_header_frame_receiver.sv =====
// sync header frame receiver top level: one result transfer per input transfer
// each result is registered: into the output register, or into the skid entry while the output stalls
// throughput: one byte per cycle while the skid entry is free; the parser state updates on every taken byte
// rst (synchronous, active high) returns to header gathering with count zero
// depends on shfr_pkg, shfr_core, shfr_skid
module sync_header_frame_receiver import shfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // input channel: one received serial byte per transfer
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  // output channel: one result per input byte
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [7:0] data_byte,
  output logic [8:0] byte_index,
  output logic [7:0] msg_length,
  output logic [7:0] msg_kind,
  output logic       last
);

  result_t core_res;
  result_t out_res;
  logic    take;

  // a byte is taken whenever the skid entry is free
  assign take = in_valid && !in_stall;

  // parser state advances only on a taken byte
  shfr_core u_core (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx_byte),
    .res     (core_res)
  );

  // result register plus one skid entry, so a byte is still taken while the output stalls
  shfr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_res    (core_res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // unpack the result onto the field ports
  assign status     = out_res.status;
  assign data_byte  = out_res.data_byte;
  assign byte_index = out_res.byte_index;
  assign msg_length = out_res.msg_length;
  assign msg_kind   = out_res.msg_kind;
  assign last       = out_res.last;

endmodule

// ===== hdl/shfr_core.sv =====
// frame parser: header gathering, sync check, payload counting
// depends on shfr_pkg
module shfr_core import shfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] rx_byte,
  output result_t    res
);

  logic       phase;
  logic       phase_next;
  logic [8:0] byte_count;
  logic [8:0] byte_count_next;
  logic [7:0] header_bytes [4];
  logic [7:0] frame_length;
  logic [7:0] frame_length_next;
  logic [7:0] frame_kind;
  logic [7:0] frame_kind_next;

  logic [15:0] len_raw;
  logic [7:0]  len_sat;
  logic        sync_ok;
  logic [8:0]  count_inc;
  logic [8:0]  frame_end;

  assign len_raw   = {header_bytes[3], header_bytes[2]};
  assign len_sat   = (len_raw > 16'(MAX_LEN)) ? 8'(MAX_LEN) : len_raw[7:0];
  assign sync_ok   = (header_bytes[0] == SYNC_BYTE) && (header_bytes[1] == SYNC_BYTE);
  assign count_inc = byte_count + 9'd1;
  assign frame_end = {1'b0, frame_length} + 9'(PAYLOAD_EXTRA);

  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    frame_length_next = frame_length;
    frame_kind_next   = frame_kind;
    res.status        = ST_HDR_STORED;
    res.data_byte     = rx_byte;
    res.byte_index    = byte_count;
    res.msg_length    = 8'd0;
    res.msg_kind      = 8'd0;
    res.last          = 1'b0;
    if (phase == PH_HEADER) begin
      if (byte_count < 9'(HDR_SIZE - 1)) begin
        byte_count_next = count_inc;
      end else begin
        byte_count_next = 9'd0;
        if (sync_ok) begin
          frame_length_next = len_sat;
          frame_kind_next   = rx_byte;
          phase_next        = PH_PAYLOAD;
          res.status        = ST_HDR_ACCEPT;
          res.msg_length    = len_sat;
          res.msg_kind      = rx_byte;
        end else begin
          res.status = ST_HDR_REJECT;
        end
      end
    end else begin
      res.status      = ST_PAYLOAD;
      res.msg_length  = frame_length;
      res.msg_kind    = frame_kind;
      byte_count_next = count_inc;
      if (count_inc >= frame_end) begin
        res.last        = 1'b1;
        phase_next      = PH_HEADER;
        byte_count_next = 9'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      byte_count   <= 9'd0;
      frame_length <= 8'd0;
      frame_kind   <= 8'd0;
    end else if (take) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      frame_length <= frame_length_next;
      frame_kind   <= frame_kind_next;
    end
  end

  // header store, no reset: always written before the sync check reads it
  always_ff @(posedge clk) begin
    if (take && (phase == PH_HEADER) && (byte_count < 9'(HDR_SIZE - 1))) begin
      header_bytes[byte_count[1:0]] <= rx_byte;
    end
  end

endmodule

// ===== hdl/shfr_skid.sv =====
// result register with one skid entry between the parser and the output port
// depends on shfr_pkg
module shfr_skid import shfr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  result_t in_res,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  logic    skid_valid;
  result_t skid_res;
  logic    pop;
  logic    push;

  assign in_stall = skid_valid;
  assign pop      = out_valid && !out_stall;
  assign push     = in_valid && !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_res <= skid_res;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_res <= in_res;
      end else begin
        skid_res <= in_res;
      end
    end
  end

endmodule

// ===== verif/shfr_checker.sv =====
// result checker for the sync header frame receiver: watches both channels,
// predicts each result from the accepted bytes and compares field by field
// depends on shfr_pkg
module shfr_checker import shfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [7:0]  data_byte,
  input  logic [8:0]  byte_index,
  input  logic [7:0]  msg_length,
  input  logic [7:0]  msg_kind,
  input  logic        last,
  output int unsigned fail_count,
  output int unsigned pending
);

  // shadow parser state
  logic        hdr_phase;
  int unsigned taken;
  logic [7:0]  hdr_bytes [4];
  int unsigned frame_len;
  logic [7:0]  frame_kind;

  result_t expected_results [$];

  function automatic result_t parse_byte(input logic [7:0] b);
    result_t     r;
    logic [15:0] sync_word;
    logic [15:0] len_word;
    r = '0;
    r.data_byte = b;
    r.byte_index = 9'(taken);
    if (hdr_phase == PH_HEADER) begin
      if (taken < HDR_SIZE - 1) begin
        hdr_bytes[2'(taken)] = b;
        taken = taken + 1;
        r.status = ST_HDR_STORED;
      end else begin
        sync_word = {hdr_bytes[1], hdr_bytes[0]};
        taken = 0;
        if (sync_word == {SYNC_BYTE, SYNC_BYTE}) begin
          len_word = {hdr_bytes[3], hdr_bytes[2]};
          frame_len = (len_word > MAX_LEN) ? MAX_LEN : len_word;
          frame_kind = b;
          hdr_phase = PH_PAYLOAD;
          r.status = ST_HDR_ACCEPT;
          r.msg_length = 8'(frame_len);
          r.msg_kind = frame_kind;
        end else begin
          r.status = ST_HDR_REJECT;
        end
      end
    end else begin
      r.status = ST_PAYLOAD;
      r.msg_length = 8'(frame_len);
      r.msg_kind = frame_kind;
      taken = taken + 1;
      if (taken >= frame_len + PAYLOAD_EXTRA) begin
        r.last = 1'b1;
        hdr_phase = PH_HEADER;
        taken = 0;
      end
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [8:0] want,
                                      input logic [8:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      fail_count = fail_count + 1;
    end
  endfunction

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      hdr_phase = PH_HEADER;
      taken = 0;
      frame_len = 0;
      frame_kind = '0;
      expected_results.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(parse_byte(rx_byte));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual status %0d byte %0d",
                   $time, status, data_byte);
          fail_count = fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 9'(want.status), 9'(status));
          check_field("data_byte", 9'(want.data_byte), 9'(data_byte));
          check_field("byte_index", want.byte_index, byte_index);
          check_field("msg_length", 9'(want.msg_length), 9'(msg_length));
          check_field("msg_kind", 9'(want.msg_kind), 9'(msg_kind));
          check_field("last", 9'(want.last), 9'(last));
        end
      end
      pending <= expected_results.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// testbench top for the sync header frame receiver: clock, reset, byte stimulus,
// random output stalls and the final verdict
// depends on shfr_pkg, sync_header_frame_receiver and shfr_checker
module tb_top import shfr_pkg::*; ();

  // run length and watchdog
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  // cycles to watch for stray results after the last expected one
  localparam int unsigned TAIL_CYCLES  = 20;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] status;
  logic [7:0] data_byte;
  logic [8:0] byte_index;
  logic [7:0] msg_length;
  logic [7:0] msg_kind;
  logic       last;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  // when set the sender pushes back to back, no gaps
  logic        tx_calm = 1'b0;

  sync_header_frame_receiver uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .data_byte  (data_byte),
    .byte_index (byte_index),
    .msg_length (msg_length),
    .msg_kind   (msg_kind),
    .last       (last)
  );

  // watches both channels and keeps the scoreboard
  shfr_checker frame_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .data_byte  (data_byte),
    .byte_index (byte_index),
    .msg_length (msg_length),
    .msg_kind   (msg_kind),
    .last       (last),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run as a failure
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // receiver back-pressure: short random bursts, a few long stalls,
  // and now and then a long calm stretch with no stall at all
  always @(posedge clk) begin : stall_gen
    int unsigned pick;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(50, 200);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        stall_left = (pick < 90) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      end
    end else begin
      stall_left = stall_left - 1;
    end
  end

  // one byte transfer; valid stays high into the next byte unless a gap is taken
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (tx_calm || pick < 60) gap = 0;
    else if (pick < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] len_lo, input logic [7:0] len_hi,
                             input logic [7:0] kind);
    send_byte(b0);
    send_byte(b1);
    send_byte(len_lo);
    send_byte(len_hi);
    send_byte(kind);
  endtask

  // well-formed frame with random payload; payload runs length plus five bytes
  task automatic send_frame(input logic [15:0] len_word, input logic [7:0] kind);
    int unsigned n;
    send_header(SYNC_BYTE, SYNC_BYTE, len_word[7:0], len_word[15:8], kind);
    n = ((len_word > MAX_LEN) ? MAX_LEN : len_word) + PAYLOAD_EXTRA;
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  // sender holds off until every expected result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned pick;
    int unsigned seq_count;
    int unsigned flip_pos;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [15:0] near_sync;
    logic [15:0] len_word;
    logic        drained_mid;
    seq_count = 0;
    drained_mid = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // zero length frame: five payload bytes still follow, kind at its top value
    send_header(SYNC_BYTE, SYNC_BYTE, 8'h00, 8'h00, 8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'h80);
    send_byte(8'h01);
    // bad second sync byte: whole header dropped
    send_header(SYNC_BYTE, 8'hA5, 8'h12, 8'h34, 8'h56);
    // bad first sync byte, max length field: no resync, next byte starts a header
    send_header(8'h00, SYNC_BYTE, 8'hFF, 8'hFF, 8'h00);
    wait_drained();

    // random part: mostly well-formed frames, some broken headers
    while (bytes_sent < RANDOM_ITEMS + 20) begin
      tx_calm = ($urandom_range(0, 7) == 0);
      if (!drained_mid && bytes_sent >= RANDOM_ITEMS / 2) begin
        wait_drained();
        drained_mid = 1'b1;
      end
      pick = $urandom_range(0, 999);
      if (seq_count == 0) begin
        // length far above the limit saturates
        send_frame(16'hFFFF, 8'($urandom_range(0, 255)));
      end else if (pick < 650) begin
        send_frame(16'($urandom_range(0, 12)), 8'($urandom_range(0, 255)));
      end else if (pick < 780) begin
        send_frame(16'($urandom_range(13, 80)), 8'($urandom_range(0, 255)));
      end else if (pick < 795) begin
        case ($urandom_range(0, 3))
          0:       len_word = 16'(MAX_LEN);
          1:       len_word = 16'(MAX_LEN + 1);
          2:       len_word = 16'hFFFF;
          default: len_word = 16'($urandom_range(256, 65535));
        endcase
        send_frame(len_word, 8'($urandom_range(0, 255)));
      end else if (pick < 900) begin
        // random header that cannot carry the sync word
        b0 = 8'($urandom_range(0, 255));
        b1 = 8'($urandom_range(0, 255));
        if ({b1, b0} == {SYNC_BYTE, SYNC_BYTE}) b1 = b1 ^ 8'h01;
        send_header(b0, b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      end else begin
        // near miss: one bit of the sync word flipped
        flip_pos = $urandom_range(0, 15);
        near_sync = {SYNC_BYTE, SYNC_BYTE} ^ (16'h0001 << flip_pos);
        send_header(near_sync[7:0], near_sync[15:8], 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
      seq_count++;
    end

    // drain, then watch a little longer for stray results
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
